[src/pu_pkg.sv]
package pu_pkg;

	// sizing of the unranker
	localparam int MAX_ITEMS  = 8;
	localparam int VALUE_BITS = 4;
	localparam int INDEX_BITS = 16;

	// configuration register widths and codes
	localparam int NUM_W     = 4;
	localparam int TABLE_W   = 32;
	localparam int LIMIT_W   = 16;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_VALUES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_TABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX_LIMIT = 2'd2;

	localparam logic [NUM_W-1:0]   RST_NUM_VALUES  = 4'd8;
	localparam logic [TABLE_W-1:0] RST_VALUE_TABLE = 32'h7654_3210;
	localparam logic [LIMIT_W-1:0] RST_INDEX_LIMIT = 16'd40320;

	// result field widths
	localparam int POS_W       = 3;
	localparam int OUT_VALUE_W = 4;

	// derived sizes
	localparam int RADIX_W = $clog2(MAX_ITEMS + 1);
	localparam int SLOT_W  = $clog2(MAX_ITEMS);
	localparam int SHIFT   = INDEX_BITS + RADIX_W;
	localparam int RECIP_W = SHIFT + 1;
	localparam int CMP_W   = (INDEX_BITS > LIMIT_W) ? INDEX_BITS : LIMIT_W;

	typedef struct packed {
		logic [INDEX_BITS-1:0] rank;
		logic                  oor;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]       position;
		logic [OUT_VALUE_W-1:0] value;
		logic                   last;
		logic                   oor;
	} result_t;

	typedef struct packed {
		logic [NUM_W-1:0]   num_values;
		logic [TABLE_W-1:0] value_table;
	} cfg_t;

endpackage

[src/pu_front.sv]
module pu_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [pu_pkg::INDEX_BITS-1:0] perm_index,
	input  logic [pu_pkg::LIMIT_W-1:0]    index_limit,
	output pu_pkg::item_t                 item,
	output logic                          item_valid,
	input  logic                          item_take
);
	import pu_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      incoming;
	logic       do_push;
	logic       do_pop;

	// range check on the way in
	always_comb begin
		incoming.rank = perm_index;
		incoming.oor  = CMP_W'(perm_index) >= CMP_W'(index_limit);
	end

	assign full       = count_q == 2'd2;
	assign item_valid = count_q != 2'd0;
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

endmodule

[src/pu_back.sv]
module pu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pu_pkg::cfg_t    cfg,
	input  pu_pkg::item_t   item,
	input  logic            item_valid,
	output logic            item_take,
	output pu_pkg::result_t res,
	output logic            res_push,
	input  logic            res_full
);
	import pu_pkg::*;

	// digit sequencer
	logic                  active_q;
	logic [INDEX_BITS-1:0] rank_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [SLOT_W-1:0]     pos_q;

	logic                  advance;
	logic                  have_work;
	logic                  start;
	logic [INDEX_BITS-1:0] dividend;
	logic [RADIX_W-1:0]    radix;
	logic [SLOT_W-1:0]     pos;
	logic                  oor;
	logic                  last_step;
	logic [RADIX_W-1:0]    n_eff;

	logic [RECIP_W-1:0]            recip_tab [MAX_ITEMS+1];
	logic [INDEX_BITS+RECIP_W-1:0] prod;
	logic [INDEX_BITS-1:0]         quot;

	// divide stage
	logic                  v_s1;
	logic [INDEX_BITS-1:0] dividend_s1;
	logic [INDEX_BITS-1:0] quot_s1;
	logic [RADIX_W-1:0]    radix_s1;
	logic [SLOT_W-1:0]     pos_s1;
	logic                  last_s1;
	logic                  oor_s1;
	logic                  first_s1;

	// working list, kept reversed so the tail element sits in slot 0
	logic [VALUE_BITS-1:0] work_q    [MAX_ITEMS];
	logic [VALUE_BITS-1:0] load      [MAX_ITEMS];
	logic [VALUE_BITS-1:0] cur       [MAX_ITEMS];
	logic [VALUE_BITS-1:0] work_next [MAX_ITEMS];

	logic [INDEX_BITS-1:0] rem_full;
	logic [RADIX_W-1:0]    rem;
	logic [RADIX_W-1:0]    top;
	logic [SLOT_W-1:0]     addr;
	logic [VALUE_BITS-1:0] emitted;
	logic                  fire2;

	// reciprocals ceil(2^SHIFT / d), exact quotient for any rank
	assign recip_tab[0] = '0;
	for (genvar gd = 1; gd <= MAX_ITEMS; gd++) begin : g_recip
		localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(gd) - 64'd1) / 64'(gd);
		assign recip_tab[gd] = RECIP_W'(RECIP);
	end

	always_comb begin
		if (cfg.num_values == '0) begin
			n_eff = RADIX_W'(1);
		end else if (8'(cfg.num_values) > 8'(MAX_ITEMS)) begin
			n_eff = RADIX_W'(MAX_ITEMS);
		end else begin
			n_eff = RADIX_W'(cfg.num_values);
		end
	end

	assign advance   = !v_s1 || !res_full;
	assign have_work = active_q || item_valid;
	assign start     = !active_q;
	assign item_take = advance && start && item_valid;

	always_comb begin
		if (start) begin
			dividend = item.rank;
			radix    = n_eff;
			pos      = '0;
			oor      = item.oor;
		end else begin
			dividend = rank_q;
			radix    = radix_q;
			pos      = pos_q;
			oor      = 1'b0;
		end
		last_step = oor || (radix == RADIX_W'(1));
		prod      = dividend * recip_tab[radix];
		quot      = INDEX_BITS'(prod >> SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			v_s1     <= 1'b0;
		end else if (advance) begin
			v_s1     <= have_work;
			active_q <= have_work && !last_step;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && have_work) begin
			rank_q      <= quot;
			radix_q     <= radix - RADIX_W'(1);
			pos_q       <= pos + SLOT_W'(1);
			dividend_s1 <= dividend;
			quot_s1     <= quot;
			radix_s1    <= radix;
			pos_s1      <= pos;
			last_s1     <= last_step;
			oor_s1      <= oor;
			first_s1    <= start;
		end
	end

	// list stage: pick the digit's element, move the tail into its slot
	always_comb begin
		for (int j = 0; j < MAX_ITEMS; j++) begin
			load[j] = VALUE_BITS'(cfg.value_table >>
				(32'(n_eff - RADIX_W'(1) - RADIX_W'(j)) * VALUE_BITS));
			cur[j]  = first_s1 ? load[j] : work_q[j];
		end
		rem_full = dividend_s1 - INDEX_BITS'(quot_s1 * INDEX_BITS'(radix_s1));
		rem      = RADIX_W'(rem_full);
		top      = radix_s1 - RADIX_W'(1);
		addr     = SLOT_W'(top - rem);
		emitted  = cur[addr];
		for (int j = 0; j < MAX_ITEMS; j++) begin
			if (j < MAX_ITEMS - 1) begin
				work_next[j] = (SLOT_W'(j + 1) == addr) ? cur[0] : cur[j+1];
			end else begin
				work_next[j] = cur[j];
			end
		end
	end

	assign fire2    = v_s1 && !res_full;
	assign res_push = fire2;

	always_comb begin
		res.position = POS_W'(pos_s1);
		res.value    = oor_s1 ? '0 : OUT_VALUE_W'(emitted);
		res.last     = last_s1;
		res.oor      = oor_s1;
	end

	always_ff @(posedge clk) begin
		if (fire2) begin
			work_q <= work_next;
		end
	end

endmodule

[src/pu_result_fifo.sv]
module pu_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  pu_pkg::result_t wr_data,
	input  logic            wr_en,
	output logic            full,
	output pu_pkg::result_t rd_data,
	output logic            empty,
	input  logic            pop
);
	import pu_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign rd_data = slot_q[rd_ptr_q];
	assign do_push = wr_en && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[src/permutation_unrank.sv]
// channel   direction  handshake              payload
// index     in         push / full            perm_index
// result    out        pop / empty            position, value, last, out_of_range
// config    in         cfg_we (no wait)       cfg_index, cfg_data
//
// one rank gives n result beats (n = num_values clamped to 1..MAX_ITEMS), one per
// cycle while results are drained; an out-of-range rank gives one beat
// first beat passes the input queue, the divide stage and the result queue before
// empty goes low; the digit loop (one reciprocal multiply per digit) sets the pace
// arst_n clears all queues and the sequencer and loads the register reset values
// a full result queue (no pop) stalls the list stage and the digit loop; two ranks queue up front
module permutation_unrank (
	input  logic                          clk,
	input  logic                          arst_n,
	// index beats
	input  logic                          push,
	output logic                          full,
	input  logic [pu_pkg::INDEX_BITS-1:0] perm_index,
	// result beats
	output logic                          empty,
	input  logic                          pop,
	output logic [pu_pkg::POS_W-1:0]      position,
	output logic [pu_pkg::OUT_VALUE_W-1:0] value,
	output logic                          last,
	output logic                          out_of_range,
	// register writes
	input  logic                          cfg_we,
	input  logic [pu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pu_pkg::CFG_W-1:0]      cfg_data
);
	import pu_pkg::*;

	// configuration registers
	logic [NUM_W-1:0]   num_values_q;
	logic [TABLE_W-1:0] value_table_q;
	logic [LIMIT_W-1:0] index_limit_q;
	cfg_t               cfg;

	// front to back
	item_t item;
	logic  item_valid;
	logic  item_take;

	// back to result queue
	result_t res;
	logic    res_push;
	logic    res_full;
	result_t head;

	// writes to unknown indices fall through the default arm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_values_q  <= RST_NUM_VALUES;
			value_table_q <= RST_VALUE_TABLE;
			index_limit_q <= RST_INDEX_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_VALUES: begin
					num_values_q <= NUM_W'(cfg_data);
				end
				REG_VALUE_TABLE: begin
					value_table_q <= TABLE_W'(cfg_data);
				end
				REG_INDEX_LIMIT: begin
					index_limit_q <= LIMIT_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.num_values  = num_values_q;
		cfg.value_table = value_table_q;
	end

	// input queue with the range check
	pu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.perm_index  (perm_index),
		.index_limit (index_limit_q),
		.item        (item),
		.item_valid  (item_valid),
		.item_take   (item_take)
	);

	// digit loop and working list
	pu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res        (res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	// result beats wait here for pop
	pu_result_fifo u_result_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (res),
		.wr_en   (res_push),
		.full    (res_full),
		.rd_data (head),
		.empty   (empty),
		.pop     (pop)
	);

	assign position     = head.position;
	assign value        = head.value;
	assign last         = head.last;
	assign out_of_range = head.oor;

endmodule
